[rtl/core/wbxml_pkg.sv]
// ----------------------------------------------------------------------------
// wbxml_pkg
// Shared types and token codes for the wbxml token decoder.
// ----------------------------------------------------------------------------
package wbxml_pkg;

   // nesting depth limit, clipped to the 8-bit depth field
   localparam int MAX_DEPTH = 255;
   localparam logic [7:0] DEPTH_CAP = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

   // global tokens
   localparam logic [7:0] TOK_SWITCH_PAGE = 8'h00;
   localparam logic [7:0] TOK_END         = 8'h01;
   localparam logic [7:0] TOK_ENTITY      = 8'h02;
   localparam logic [7:0] TOK_STR_I       = 8'h03;
   localparam logic [7:0] TOK_LITERAL     = 8'h04;
   localparam logic [7:0] TOK_EXT_I_0     = 8'h40;
   localparam logic [7:0] TOK_EXT_I_1     = 8'h41;
   localparam logic [7:0] TOK_EXT_I_2     = 8'h42;
   localparam logic [7:0] TOK_PI          = 8'h43;
   localparam logic [7:0] TOK_EXT_T_0     = 8'h80;
   localparam logic [7:0] TOK_EXT_T_1     = 8'h81;
   localparam logic [7:0] TOK_EXT_T_2     = 8'h82;
   localparam logic [7:0] TOK_STR_T       = 8'h83;
   localparam logic [7:0] TOK_EXT_0       = 8'hc0;
   localparam logic [7:0] TOK_EXT_1       = 8'hc1;
   localparam logic [7:0] TOK_EXT_2       = 8'hc2;
   localparam logic [7:0] TOK_OPAQUE      = 8'hc3;
   localparam logic [7:0] PI_TERM         = 8'h01;
   localparam logic [5:0] TAG_LITERAL     = 6'h04;
   localparam logic [6:0] ATTR_LIT_CODE   = 7'h04;

   typedef enum logic [2:0] {
      MODE_INT,
      MODE_SKIP,
      MODE_TOKEN,
      MODE_PAGE,
      MODE_STRI,
      MODE_SKIPSTR,
      MODE_PI
   } mode_type;

   typedef enum logic [2:0] {
      USE_TABLE_LEN,
      USE_ENTITY,
      USE_STR_T,
      USE_EXT_T,
      USE_OPAQUE,
      USE_ATTR_LIT,
      USE_ELEM_LIT
   } use_type;

   typedef enum logic [3:0] {
      EV_ELEM_START = 4'd0,
      EV_ELEM_END   = 4'd1,
      EV_ATTR_START = 4'd2,
      EV_ATTR_VALUE = 4'd3,
      EV_ATTRS_END  = 4'd4,
      EV_STR_BYTE   = 4'd5,
      EV_STR_END    = 4'd6,
      EV_TABLE_STR  = 4'd7,
      EV_ENTITY     = 4'd8
   } event_kind_type;

   typedef enum logic [1:0] {
      DEPTH_HOLD,
      DEPTH_DOWN,
      DEPTH_UP
   } depth_op_type;

   typedef struct packed {
      logic           valid;
      event_kind_type kind;
      logic [6:0]     code;
      logic [7:0]     page;
      logic [31:0]    value;
      logic           literal;
      logic           has_attr;
      logic           has_content;
      depth_op_type   depth_op;
   } parse_event_type;

endpackage

[rtl/core/wbxml_if.sv]
// ----------------------------------------------------------------------------
// wbxml_req_if / wbxml_rsp_if
// Valid/ready channels for document bytes and decoded events.
// ----------------------------------------------------------------------------
interface wbxml_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       doc_start;

   modport source (output valid, in_byte, doc_start, input ready);
   modport sink   (input valid, in_byte, doc_start, output ready);
endinterface

interface wbxml_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  event_kind;
   logic [6:0]  token_code;
   logic [7:0]  code_page;
   logic [31:0] value_word;
   logic        is_literal;
   logic        has_attributes;
   logic        has_content;
   logic [7:0]  depth_now;
   logic        depth_error;

   modport source (output valid, event_kind, token_code, code_page, value_word,
                   is_literal, has_attributes, has_content, depth_now, depth_error,
                   input ready);
   modport sink   (input valid, event_kind, token_code, code_page, value_word,
                   is_literal, has_attributes, has_content, depth_now, depth_error,
                   output ready);
endinterface

[rtl/core/wbxml_depth.sv]
// ----------------------------------------------------------------------------
// wbxml_depth
// Element nesting depth counter with saturation at the cap and at zero.
// ----------------------------------------------------------------------------
module wbxml_depth import wbxml_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         clear,
   input  depth_op_type op,
   output logic [7:0]   depth_now,
   output logic         depth_error
);

   logic [7:0] depth_ff;
   logic [7:0] depth_in;
   logic [7:0] base;

   always_comb begin
      base        = clear ? 8'd0 : depth_ff;
      depth_in    = base;
      depth_error = 1'b0;
      case (op)
         DEPTH_DOWN: begin
            if (base >= DEPTH_CAP) depth_error = 1'b1;
            else depth_in = base + 8'd1;
         end
         DEPTH_UP: begin
            if (base == 8'd0) depth_error = 1'b1;
            else depth_in = base - 8'd1;
         end
         default: depth_in = base;
      endcase
      depth_now = depth_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= 8'd0;
      end else if (step) begin
         depth_ff <= depth_in;
      end
   end

`ifndef SYNTHESIS
   a_depth_capped: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_CAP) else $error("depth above cap");
`endif

endmodule

[rtl/core/wbxml_parse.sv]
// ----------------------------------------------------------------------------
// wbxml_parse
// Byte-level parser state machine: multibyte integers, skips, code pages,
// inline strings and tag/attribute token decode.
// ----------------------------------------------------------------------------
module wbxml_parse import wbxml_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      in_byte,
   input  logic            doc_start,
   output parse_event_type ev
);

   mode_type    mode_ff, mode_in, mode_cur;
   use_type     purpose_ff, purpose_in, purpose_cur;
   logic [31:0] accum_ff, accum_in, accum_cur, accum_shift;
   logic [31:0] skip_ff, skip_in, skip_cur;
   logic [7:0]  held_ff, held_in, held_cur;
   logic [7:0]  tag_page_ff, tag_page_in, tag_page_cur;
   logic [7:0]  attr_page_ff, attr_page_in, attr_page_cur;
   logic        in_attr_ff, in_attr_in, in_attr_cur;
   logic        content_ff, content_in, content_cur;

   logic        elem_go;
   logic [7:0]  elem_tok;
   logic [31:0] elem_val;
   logic        elem_lit;
   logic        int_go;
   use_type     int_use;

   // a document start byte sees the reset state
   always_comb begin
      if (doc_start) begin
         mode_cur      = MODE_INT;
         purpose_cur   = USE_TABLE_LEN;
         accum_cur     = '0;
         skip_cur      = '0;
         held_cur      = '0;
         tag_page_cur  = '0;
         attr_page_cur = '0;
         in_attr_cur   = 1'b0;
         content_cur   = 1'b0;
      end else begin
         mode_cur      = mode_ff;
         purpose_cur   = purpose_ff;
         accum_cur     = accum_ff;
         skip_cur      = skip_ff;
         held_cur      = held_ff;
         tag_page_cur  = tag_page_ff;
         attr_page_cur = attr_page_ff;
         in_attr_cur   = in_attr_ff;
         content_cur   = content_ff;
      end
   end

   assign accum_shift = {accum_cur[24:0], in_byte[6:0]};

   always_comb begin
      mode_in      = mode_cur;
      purpose_in   = purpose_cur;
      accum_in     = accum_cur;
      skip_in      = skip_cur;
      held_in      = held_cur;
      tag_page_in  = tag_page_cur;
      attr_page_in = attr_page_cur;
      in_attr_in   = in_attr_cur;
      content_in   = content_cur;
      ev           = '0;
      ev.kind      = EV_ELEM_START;
      ev.depth_op  = DEPTH_HOLD;
      elem_go      = 1'b0;
      elem_tok     = in_byte;
      elem_val     = '0;
      elem_lit     = 1'b0;
      int_go       = 1'b0;
      int_use      = USE_EXT_T;

      case (mode_cur)
         MODE_INT: begin
            if (in_byte[7]) begin
               accum_in = accum_shift;
            end else begin
               accum_in = '0;
               mode_in  = MODE_TOKEN;
               case (purpose_cur)
                  USE_TABLE_LEN, USE_OPAQUE: begin
                     if (accum_shift != 32'd0) begin
                        skip_in = accum_shift;
                        mode_in = MODE_SKIP;
                     end
                  end
                  USE_ENTITY: begin
                     ev.valid = 1'b1;
                     ev.kind  = EV_ENTITY;
                     ev.value = accum_shift;
                  end
                  USE_STR_T: begin
                     ev.valid = 1'b1;
                     ev.kind  = EV_TABLE_STR;
                     ev.value = accum_shift;
                  end
                  USE_ATTR_LIT: begin
                     ev.valid   = 1'b1;
                     ev.kind    = EV_ATTR_START;
                     ev.code    = ATTR_LIT_CODE;
                     ev.page    = attr_page_cur;
                     ev.value   = accum_shift;
                     ev.literal = 1'b1;
                  end
                  USE_ELEM_LIT: begin
                     elem_go  = 1'b1;
                     elem_tok = held_cur;
                     elem_val = accum_shift;
                     elem_lit = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         MODE_SKIP: begin
            skip_in = (skip_cur == 32'd0) ? 32'd0 : skip_cur - 32'd1;
            if (skip_cur <= 32'd1) mode_in = MODE_TOKEN;
         end
         MODE_PAGE: begin
            if (in_attr_cur) attr_page_in = in_byte;
            else tag_page_in = in_byte;
            mode_in = MODE_TOKEN;
         end
         MODE_STRI: begin
            ev.valid = 1'b1;
            if (in_byte == 8'd0) begin
               mode_in = MODE_TOKEN;
               ev.kind = EV_STR_END;
            end else begin
               ev.kind  = EV_STR_BYTE;
               ev.value = {24'd0, in_byte};
            end
         end
         MODE_SKIPSTR: begin
            if (in_byte == 8'd0) mode_in = MODE_TOKEN;
         end
         MODE_PI: begin
            if (in_byte == PI_TERM) mode_in = MODE_TOKEN;
         end
         default: begin
            mode_in = MODE_TOKEN;
            case (in_byte)
               TOK_SWITCH_PAGE: mode_in = MODE_PAGE;
               TOK_ENTITY: begin
                  int_go  = 1'b1;
                  int_use = USE_ENTITY;
               end
               TOK_STR_I: mode_in = MODE_STRI;
               TOK_EXT_I_0, TOK_EXT_I_1, TOK_EXT_I_2: mode_in = MODE_SKIPSTR;
               TOK_PI: mode_in = MODE_PI;
               TOK_EXT_T_0, TOK_EXT_T_1, TOK_EXT_T_2: begin
                  int_go  = 1'b1;
                  int_use = USE_EXT_T;
               end
               TOK_STR_T: begin
                  int_go  = 1'b1;
                  int_use = USE_STR_T;
               end
               TOK_EXT_0, TOK_EXT_1, TOK_EXT_2: ;
               TOK_OPAQUE: begin
                  int_go  = 1'b1;
                  int_use = USE_OPAQUE;
               end
               default: begin
                  if (in_attr_cur) begin
                     if (in_byte[7]) begin
                        ev.valid = 1'b1;
                        ev.kind  = EV_ATTR_VALUE;
                        ev.code  = in_byte[6:0];
                        ev.page  = attr_page_cur;
                     end else if (in_byte == TOK_END) begin
                        in_attr_in = 1'b0;
                        ev.valid   = 1'b1;
                        ev.kind    = EV_ATTRS_END;
                        ev.page    = attr_page_cur;
                        if (!content_cur) ev.depth_op = DEPTH_UP;
                     end else if (in_byte == TOK_LITERAL) begin
                        int_go  = 1'b1;
                        int_use = USE_ATTR_LIT;
                     end else begin
                        ev.valid = 1'b1;
                        ev.kind  = EV_ATTR_START;
                        ev.code  = in_byte[6:0];
                        ev.page  = attr_page_cur;
                     end
                  end else if (in_byte == TOK_END) begin
                     ev.valid    = 1'b1;
                     ev.kind     = EV_ELEM_END;
                     ev.page     = tag_page_cur;
                     ev.depth_op = DEPTH_UP;
                  end else if (in_byte[5:0] == TAG_LITERAL) begin
                     held_in = in_byte;
                     int_go  = 1'b1;
                     int_use = USE_ELEM_LIT;
                  end else begin
                     elem_go = 1'b1;
                  end
               end
            endcase
         end
      endcase

      // start of a multibyte integer
      if (int_go) begin
         accum_in   = '0;
         purpose_in = int_use;
         mode_in    = MODE_INT;
      end

      // element start, from a plain tag or a literal one
      if (elem_go) begin
         in_attr_in     = elem_tok[7];
         content_in     = elem_tok[6];
         ev.valid       = 1'b1;
         ev.kind        = EV_ELEM_START;
         ev.code        = {1'b0, elem_tok[5:0]};
         ev.page        = tag_page_cur;
         ev.value       = elem_val;
         ev.literal     = elem_lit;
         ev.has_attr    = elem_tok[7];
         ev.has_content = elem_tok[6];
         if (elem_tok[7] || elem_tok[6]) ev.depth_op = DEPTH_DOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INT;
         purpose_ff   <= USE_TABLE_LEN;
         accum_ff     <= '0;
         skip_ff      <= '0;
         held_ff      <= '0;
         tag_page_ff  <= '0;
         attr_page_ff <= '0;
         in_attr_ff   <= 1'b0;
         content_ff   <= 1'b0;
      end else if (step) begin
         mode_ff      <= mode_in;
         purpose_ff   <= purpose_in;
         accum_ff     <= accum_in;
         skip_ff      <= skip_in;
         held_ff      <= held_in;
         tag_page_ff  <= tag_page_in;
         attr_page_ff <= attr_page_in;
         in_attr_ff   <= in_attr_in;
         content_ff   <= content_in;
      end
   end

`ifndef SYNTHESIS
   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SKIP |-> skip_ff != 32'd0) else $error("skip mode with zero count");
`endif

endmodule

[rtl/core/wbxml_token_decoder.sv]
// ----------------------------------------------------------------------------
// wbxml_token_decoder
// Decodes a WBXML byte stream into element, attribute, string and entity events.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   valid/ready          in_byte, doc_start
//  rsp      out  valid/ready          event_kind .. depth_error
//
//  one byte per cycle unless rsp stalls; a byte passes input, then result register
//  the parser state register loop (mode, integer, skip count) sets that rate
//  each byte gives zero or one event; bytes without an event leave no bubble
//  reset is synchronous and clears parser, depth and valid flags
//  rsp stalls hold the result register and back up through the input register
// ----------------------------------------------------------------------------
module wbxml_token_decoder import wbxml_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wbxml_req_if.sink   req,
   wbxml_rsp_if.source rsp
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            doc_start_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            step;
   parse_event_type ev;
   logic [7:0]      depth_next;
   logic            depth_err;

   logic [3:0]  kind_ff;
   logic [6:0]  code_ff;
   logic [7:0]  page_ff;
   logic [31:0] value_ff;
   logic        literal_ff;
   logic        has_attr_ff;
   logic        has_content_ff;
   logic [7:0]  depth_ff;
   logic        depth_err_ff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign step      = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = step && ev.valid;
   end

   wbxml_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .doc_start (doc_start_ff),
      .ev        (ev)
   );

   wbxml_depth u_depth (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .clear       (doc_start_ff),
      .op          (ev.depth_op),
      .depth_now   (depth_next),
      .depth_error (depth_err)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff   <= req.in_byte;
         doc_start_ff <= req.doc_start;
      end
      if (step && ev.valid) begin
         kind_ff        <= ev.kind;
         code_ff        <= ev.code;
         page_ff        <= ev.page;
         value_ff       <= ev.value;
         literal_ff     <= ev.literal;
         has_attr_ff    <= ev.has_attr;
         has_content_ff <= ev.has_content;
         depth_ff       <= depth_next;
         depth_err_ff   <= depth_err;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.event_kind     = kind_ff;
   assign rsp.token_code     = code_ff;
   assign rsp.code_page      = page_ff;
   assign rsp.value_word     = value_ff;
   assign rsp.is_literal     = literal_ff;
   assign rsp.has_attributes = has_attr_ff;
   assign rsp.has_content    = has_content_ff;
   assign rsp.depth_now      = depth_ff;
   assign rsp.depth_error    = depth_err_ff;

`ifndef SYNTHESIS
   a_err_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && depth_err_ff |-> (depth_ff == 8'd0 || depth_ff == DEPTH_CAP))
      else $error("depth error away from a bound");
   a_flags_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (has_attr_ff || has_content_ff) |-> kind_ff == EV_ELEM_START)
      else $error("element flags on a non-start event");
   a_held_byte: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(doc_start_ff))
      else $error("pending byte lost during stall");
`endif

endmodule

[tb/wbxml_event_checker.sv]
// ----------------------------------------------------------------------------
// wbxml_event_checker
// Watches the byte and event channels of the wbxml token decoder. It decodes
// every accepted byte with its own parser to predict events, then compares
// each accepted event field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wbxml_event_checker import wbxml_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_doc_start,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_event_kind,
   input  logic [6:0]  rsp_token_code,
   input  logic [7:0]  rsp_code_page,
   input  logic [31:0] rsp_value_word,
   input  logic        rsp_is_literal,
   input  logic        rsp_has_attributes,
   input  logic        rsp_has_content,
   input  logic [7:0]  rsp_depth_now,
   input  logic        rsp_depth_error,
   output int          mismatches,
   output int          events_pending
);

   typedef struct packed {
      event_kind_type kind;
      logic [6:0]     code;
      logic [7:0]     page;
      logic [31:0]    value;
      logic           literal;
      logic           has_attr;
      logic           has_content;
      logic [7:0]     depth;
      logic           depth_err;
   } doc_event_type;

   doc_event_type predicted_events[$];

   // parser copy
   mode_type    mode;
   use_type     int_use;
   logic [31:0] accum;
   logic [31:0] skip_left;
   logic [7:0]  held_tag;
   logic [7:0]  tag_pg;
   logic [7:0]  attr_pg;
   logic        attr_open;
   logic        content_open;
   logic [7:0]  depth;

   function automatic void clear_parser();
      mode = MODE_INT;
      int_use = USE_TABLE_LEN;
      accum = '0;
      skip_left = '0;
      held_tag = '0;
      tag_pg = '0;
      attr_pg = '0;
      attr_open = 1'b0;
      content_open = 1'b0;
      depth = '0;
   endfunction

   function automatic void start_number(use_type purpose);
      accum = '0;
      int_use = purpose;
      mode = MODE_INT;
   endfunction

   // returns 1 when the decrement was clipped at zero
   function automatic logic leave_level();
      if (depth == 8'd0) return 1'b1;
      depth = depth - 8'd1;
      return 1'b0;
   endfunction

   function automatic doc_event_type open_element(logic [7:0] tok, logic [31:0] offset,
                                                  logic lit);
      doc_event_type ev;
      ev = '0;
      attr_open = tok[7];
      content_open = tok[6];
      ev.kind = EV_ELEM_START;
      ev.code = {1'b0, tok[5:0]};
      ev.page = tag_pg;
      ev.value = offset;
      ev.literal = lit;
      ev.has_attr = tok[7];
      ev.has_content = tok[6];
      if (tok[7] || tok[6]) begin
         if (depth >= DEPTH_CAP) ev.depth_err = 1'b1;
         else depth = depth + 8'd1;
      end
      return ev;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic first);
      doc_event_type ev;
      logic          produced;
      logic [31:0]   num;
      ev = '0;
      produced = 1'b0;
      if (first) clear_parser();
      case (mode)
         MODE_INT: begin
            accum = {accum[24:0], b[6:0]};
            if (!b[7]) begin
               num = accum;
               accum = '0;
               mode = MODE_TOKEN;
               case (int_use)
                  USE_TABLE_LEN, USE_OPAQUE: begin
                     if (num != 0) begin
                        skip_left = num;
                        mode = MODE_SKIP;
                     end
                  end
                  USE_ENTITY: begin
                     produced = 1'b1;
                     ev.kind = EV_ENTITY;
                     ev.value = num;
                  end
                  USE_STR_T: begin
                     produced = 1'b1;
                     ev.kind = EV_TABLE_STR;
                     ev.value = num;
                  end
                  USE_ATTR_LIT: begin
                     produced = 1'b1;
                     ev.kind = EV_ATTR_START;
                     ev.code = ATTR_LIT_CODE;
                     ev.page = attr_pg;
                     ev.value = num;
                     ev.literal = 1'b1;
                  end
                  USE_ELEM_LIT: begin
                     produced = 1'b1;
                     ev = open_element(held_tag, num, 1'b1);
                  end
                  default: ;
               endcase
            end
         end
         MODE_SKIP: begin
            if (skip_left != 0) skip_left = skip_left - 1;
            if (skip_left == 0) mode = MODE_TOKEN;
         end
         MODE_PAGE: begin
            if (attr_open) attr_pg = b;
            else tag_pg = b;
            mode = MODE_TOKEN;
         end
         MODE_STRI: begin
            produced = 1'b1;
            if (b == 8'd0) begin
               mode = MODE_TOKEN;
               ev.kind = EV_STR_END;
            end else begin
               ev.kind = EV_STR_BYTE;
               ev.value = {24'd0, b};
            end
         end
         MODE_SKIPSTR: begin
            if (b == 8'd0) mode = MODE_TOKEN;
         end
         MODE_PI: begin
            if (b == PI_TERM) mode = MODE_TOKEN;
         end
         default: begin
            mode = MODE_TOKEN;
            case (b)
               TOK_SWITCH_PAGE: mode = MODE_PAGE;
               TOK_ENTITY: start_number(USE_ENTITY);
               TOK_STR_I: mode = MODE_STRI;
               TOK_EXT_I_0, TOK_EXT_I_1, TOK_EXT_I_2: mode = MODE_SKIPSTR;
               TOK_PI: mode = MODE_PI;
               TOK_EXT_T_0, TOK_EXT_T_1, TOK_EXT_T_2: start_number(USE_EXT_T);
               TOK_STR_T: start_number(USE_STR_T);
               TOK_EXT_0, TOK_EXT_1, TOK_EXT_2: ;
               TOK_OPAQUE: start_number(USE_OPAQUE);
               default: begin
                  produced = 1'b1;
                  if (attr_open) begin
                     if (b[7]) begin
                        ev.kind = EV_ATTR_VALUE;
                        ev.code = b[6:0];
                        ev.page = attr_pg;
                     end else if (b == TOK_END) begin
                        attr_open = 1'b0;
                        ev.kind = EV_ATTRS_END;
                        ev.page = attr_pg;
                        if (!content_open) ev.depth_err = leave_level();
                     end else if (b == TOK_LITERAL) begin
                        produced = 1'b0;
                        start_number(USE_ATTR_LIT);
                     end else begin
                        ev.kind = EV_ATTR_START;
                        ev.code = b[6:0];
                        ev.page = attr_pg;
                     end
                  end else if (b == TOK_END) begin
                     ev.kind = EV_ELEM_END;
                     ev.page = tag_pg;
                     ev.depth_err = leave_level();
                  end else if (b[5:0] == TAG_LITERAL) begin
                     produced = 1'b0;
                     held_tag = b;
                     start_number(USE_ELEM_LIT);
                  end else begin
                     ev = open_element(b, '0, 1'b0);
                  end
               end
            endcase
         end
      endcase
      ev.depth = depth;
      if (produced) predicted_events.push_back(ev);
   endtask

   function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      doc_event_type want;
      if (reset) begin
         clear_parser();
         predicted_events.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_in_byte, req_doc_start);
         if (rsp_valid && rsp_ready) begin
            if (predicted_events.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected event, expected none actual kind %0d",
                        $time, rsp_event_kind);
            end else begin
               want = predicted_events.pop_front();
               compare_field("event_kind", 32'(want.kind), 32'(rsp_event_kind));
               compare_field("token_code", 32'(want.code), 32'(rsp_token_code));
               compare_field("code_page", 32'(want.page), 32'(rsp_code_page));
               compare_field("value_word", want.value, rsp_value_word);
               compare_field("is_literal", 32'(want.literal), 32'(rsp_is_literal));
               compare_field("has_attributes", 32'(want.has_attr),
                             32'(rsp_has_attributes));
               compare_field("has_content", 32'(want.has_content), 32'(rsp_has_content));
               compare_field("depth_now", 32'(want.depth), 32'(rsp_depth_now));
               compare_field("depth_error", 32'(want.depth_err), 32'(rsp_depth_error));
            end
         end
      end
      events_pending = predicted_events.size();
   end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the wbxml token decoder: a directed document, then random
// well-formed documents with noise, truncation and one very deep document,
// under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
   import wbxml_pkg::*;

   localparam int ITEM_TARGET = 1400;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   items_sent;
   logic steady;
   logic hold_due;
   int   check_failures;
   int   events_left;
   logic [7:0] doc_bytes[$];

   wbxml_req_if req_ch();
   wbxml_rsp_if rsp_ch();

   wbxml_token_decoder DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   wbxml_event_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_in_byte        (req_ch.in_byte),
      .req_doc_start      (req_ch.doc_start),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_event_kind     (rsp_ch.event_kind),
      .rsp_token_code     (rsp_ch.token_code),
      .rsp_code_page      (rsp_ch.code_page),
      .rsp_value_word     (rsp_ch.value_word),
      .rsp_is_literal     (rsp_ch.is_literal),
      .rsp_has_attributes (rsp_ch.has_attributes),
      .rsp_has_content    (rsp_ch.has_content),
      .rsp_depth_now      (rsp_ch.depth_now),
      .rsp_depth_error    (rsp_ch.depth_error),
      .mismatches         (check_failures),
      .events_pending     (events_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // event receiver, with one long hold-off to back the decoder up
   initial begin
      logic hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_due && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 31);
         end
      end
   end

   function automatic logic [31:0] pick_number();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 127);
         1: return $urandom_range(0, 16383);
         2: return $urandom;
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   // multibyte integer, most significant group first, sometimes zero padded
   function automatic void put_varint(logic [31:0] v);
      logic [6:0]  groups[$];
      logic [31:0] rest;
      rest = v;
      do begin
         groups.push_front(rest[6:0]);
         rest = rest >> 7;
      end while (rest != 0);
      if ($urandom_range(0, 7) == 0) groups.push_front(7'd0);
      for (int i = 0; i < groups.size(); i++)
         doc_bytes.push_back({(i != groups.size() - 1), groups[i]});
   endfunction

   // lead token, a few nonzero bytes, then the zero terminator
   function automatic void put_text(logic [7:0] lead);
      doc_bytes.push_back(lead);
      repeat ($urandom_range(0, 4)) doc_bytes.push_back(8'($urandom_range(1, 255)));
      doc_bytes.push_back(8'd0);
   endfunction

   function automatic void build_document();
      int         table_len;
      int         open_levels;
      int         pick;
      logic       in_attr;
      logic [1:0] top;
      logic [7:0] tok;
      doc_bytes.delete();
      table_len = $urandom_range(0, 4);
      put_varint(32'(table_len));
      repeat (table_len) doc_bytes.push_back(8'($urandom_range(0, 255)));
      in_attr = 1'b0;
      open_levels = 0;
      repeat ($urandom_range(4, 30)) begin
         pick = $urandom_range(0, 99);
         if (in_attr) begin
            if (pick < 30) begin
               tok = 8'($urandom_range(5, 127));
               if (tok[7:2] == TOK_EXT_I_0[7:2]) tok = 8'h05;
               doc_bytes.push_back(tok);
            end else if (pick < 50) begin
               tok = 8'($urandom_range(8'h84, 8'hff));
               if (tok[7:2] == TOK_EXT_0[7:2]) tok = 8'h84;
               doc_bytes.push_back(tok);
            end else if (pick < 58) begin
               doc_bytes.push_back(TOK_LITERAL);
               put_varint(pick_number());
            end else if (pick < 66) begin
               put_text(TOK_STR_I);
            end else if (pick < 72) begin
               doc_bytes.push_back(TOK_STR_T);
               put_varint(pick_number());
            end else if (pick < 76) begin
               doc_bytes.push_back(TOK_ENTITY);
               put_varint(pick_number());
            end else if (pick < 82) begin
               doc_bytes.push_back(TOK_SWITCH_PAGE);
               doc_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               doc_bytes.push_back(TOK_END);
               in_attr = 1'b0;
            end
         end else begin
            if (pick < 35) begin
               top = 2'($urandom_range(0, 3));
               if ($urandom_range(0, 9) == 0) begin
                  doc_bytes.push_back({top, TAG_LITERAL});
                  put_varint(pick_number());
               end else begin
                  doc_bytes.push_back({top, 6'($urandom_range(5, 63))});
               end
               in_attr = top[1];
               // attribute-only elements close at the attribute end token
               if (top[0]) open_levels++;
            end else if (pick < 55) begin
               doc_bytes.push_back(TOK_END);
               if (open_levels > 0) open_levels--;
            end else if (pick < 65) begin
               put_text(TOK_STR_I);
            end else if (pick < 70) begin
               doc_bytes.push_back(TOK_ENTITY);
               put_varint(pick_number());
            end else if (pick < 74) begin
               doc_bytes.push_back(TOK_STR_T);
               put_varint(pick_number());
            end else if (pick < 78) begin
               doc_bytes.push_back(TOK_SWITCH_PAGE);
               doc_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 81) begin
               doc_bytes.push_back(TOK_PI);
               repeat ($urandom_range(0, 4)) begin
                  tok = 8'($urandom_range(0, 255));
                  if (tok == PI_TERM) tok = 8'h02;
                  doc_bytes.push_back(tok);
               end
               doc_bytes.push_back(PI_TERM);
            end else if (pick < 84) begin
               put_text(8'(TOK_EXT_I_0 + $urandom_range(0, 2)));
            end else if (pick < 87) begin
               doc_bytes.push_back(8'(TOK_EXT_T_0 + $urandom_range(0, 2)));
               put_varint(pick_number());
            end else if (pick < 89) begin
               doc_bytes.push_back(8'(TOK_EXT_0 + $urandom_range(0, 2)));
            end else if (pick < 92) begin
               table_len = $urandom_range(0, 4);
               doc_bytes.push_back(TOK_OPAQUE);
               put_varint(32'(table_len));
               repeat (table_len) doc_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               doc_bytes.push_back(8'($urandom_range(5, 63)));
            end
         end
      end
      if (in_attr) doc_bytes.push_back(TOK_END);
      repeat (open_levels) doc_bytes.push_back(TOK_END);
      // cut some documents short
      if ($urandom_range(0, 9) == 0 && doc_bytes.size() > 2)
         repeat ($urandom_range(1, doc_bytes.size() - 1)) void'(doc_bytes.pop_back());
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic first);
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.doc_start <= first;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      items_sent++;
      steady = (items_sent >= 800 && items_sent < 1000);
      if (items_sent == 300) hold_due = 1'b1;
   endtask

   task automatic send_document();
      foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == 0);
   endtask

   initial begin
      logic deep_done;
      reset = 1'b1;
      items_sent = 0;
      steady = 1'b0;
      hold_due = 1'b0;
      deep_done = 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= 8'd0;
      req_ch.doc_start <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // skipped string table, both code pages, attribute forms, inline string,
      // wrapping entity number, table string, end and an end below zero depth
      doc_bytes = '{8'd2, 8'haa, 8'h55, TOK_SWITCH_PAGE, 8'hff, {2'b11, 6'h05},
                    TOK_SWITCH_PAGE, 8'h07, 8'h05, 8'h86, TOK_LITERAL, 8'h03,
                    TOK_END, TOK_STR_I, 8'h41, 8'h00, TOK_ENTITY, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'h7f, TOK_STR_T, 8'h05, TOK_END, TOK_END};
      send_document();

      while (items_sent < ITEM_TARGET) begin
         if (!deep_done && items_sent >= 500) begin
            // nest past the depth cap, then close past zero
            deep_done = 1'b1;
            doc_bytes.delete();
            doc_bytes.push_back(8'd0);
            repeat (int'(DEPTH_CAP) + 3) doc_bytes.push_back({2'b01, 6'h05});
            repeat (int'(DEPTH_CAP) + 5) doc_bytes.push_back(TOK_END);
         end else if ($urandom_range(0, 99) < 8) begin
            doc_bytes.delete();
            repeat ($urandom_range(6, 24)) doc_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_document();
         end
         send_document();
      end
      req_ch.valid <= 1'b0;

      // let the checker take in the last request before looking at its queue
      repeat (2) @(posedge clock);
      while (events_left != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (check_failures == 0 && events_left == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

[wbxml_token_decoder.f]
rtl/core/wbxml_pkg.sv
rtl/core/wbxml_if.sv
rtl/core/wbxml_depth.sv
rtl/core/wbxml_parse.sv
rtl/core/wbxml_token_decoder.sv
tb/wbxml_event_checker.sv
tb/testbench.sv
